@@ sv/bb5_pkg.sv @@
// Shared constants and the reciprocal table of the 5x5 box blur.
`timescale 1ns / 1ps
`default_nettype none
package bb5_pkg;

  // Frame geometry limits.
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = 11;
  localparam int WIDTH_W   = 12;
  localparam int HEIGHT_W  = 16;
  localparam int LAG_W     = 13;

  // Line store: a ring of eight rows, one packed RGB pixel per entry.
  localparam int RING_ROWS = 8;
  localparam int RING_W    = 3;
  localparam int PIX_W     = 24;
  localparam int LS_DEPTH  = RING_ROWS * MAX_WIDTH;
  localparam int LS_ADDR_W = RING_W + COL_W;

  // Window walk and accumulation.
  localparam int RADIUS   = 2;
  localparam int WIN      = 2 * RADIUS + 1;
  localparam int WIDX_W   = 3;
  localparam int SUM_W    = 13;
  localparam int CNT_W    = 5;

  // Division by the neighbor count through a scaled reciprocal.
  localparam int RCP_SHIFT = 18;
  localparam int RCP_W     = 19;
  localparam int PROD_W    = SUM_W + RCP_W;

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Reciprocal ceil(2^18 / d) for counts 1..25; exact floor for sums below 6376.
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] d);
    logic [RCP_W-1:0] r;
    unique case (d)
      5'd1:    r = 19'd262144;
      5'd2:    r = 19'd131072;
      5'd3:    r = 19'd87382;
      5'd4:    r = 19'd65536;
      5'd5:    r = 19'd52429;
      5'd6:    r = 19'd43691;
      5'd7:    r = 19'd37450;
      5'd8:    r = 19'd32768;
      5'd9:    r = 19'd29128;
      5'd10:   r = 19'd26215;
      5'd11:   r = 19'd23832;
      5'd12:   r = 19'd21846;
      5'd13:   r = 19'd20165;
      5'd14:   r = 19'd18725;
      5'd15:   r = 19'd17477;
      5'd16:   r = 19'd16384;
      5'd17:   r = 19'd15421;
      5'd18:   r = 19'd14564;
      5'd19:   r = 19'd13798;
      5'd20:   r = 19'd13108;
      5'd21:   r = 19'd12484;
      5'd22:   r = 19'd11916;
      5'd23:   r = 19'd11398;
      5'd24:   r = 19'd10923;
      5'd25:   r = 19'd10486;
      default: r = 19'd262144;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/bb5_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bb5_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/box_blur_5x5_rgb_core.sv @@
// Top level of the 5x5 clipped box blur over an RGB raster stream.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one RGB pixel per beat in raster order and returns, per channel,
// the truncated mean of the original pixels in the 5x5 window around each pixel,
// clipped at the frame borders. Results lag the input by two rows plus two pixels;
// flush beats drain the tail of the frame, and frame_last marks the final result.
// A beat that yields no result needs no window walk. A beat that yields a result
// starts one: the 25 window pixels are read one per cycle from the single read port
// of the line store (a ring of eight rows), then the division by the neighbor count
// uses one reciprocal multiplier once per channel. The next beat is held off until
// the result is done and while a finished result is held in the output register
// by a stalled receiver. Writing a register restarts the frame.
module box_blur_5x5_rgb_core
  import bb5_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_red_in,
  input  wire logic [7:0]  in_green_in,
  input  wire logic [7:0]  in_blue_in,
  input  wire logic        in_flush,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic             out_frame_last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_RCP   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;

  logic [WIDTH_W-1:0]  width_cfg_r, width_cfg_nxt;
  logic [HEIGHT_W-1:0] height_cfg_r, height_cfg_nxt;
  logic [COL_W-1:0]    in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [HEIGHT_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic                in_done_r, in_done_nxt;
  logic [LAG_W-1:0]    diff_r, diff_nxt;
  logic [2:0]          state_r, state_nxt;
  logic [WIDX_W-1:0]   wy_r, wy_nxt, wx_r, wx_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [SUM_W-1:0]    sum_r_r, sum_r_nxt, sum_g_r, sum_g_nxt, sum_b_r, sum_b_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [RCP_W-1:0]    recip_r, recip_nxt;
  logic [1:0]          ch_r, ch_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;
  logic                last_r, last_nxt;

  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [LAG_W-1:0]    lag_plus;
  logic                in_acc, wr_en, in_eol, in_eof;
  logic [17:0]         yy;
  logic [12:0]         xx;
  logic                tap_in;
  logic [PIX_W-1:0]    rd_data;
  logic [SUM_W-1:0]    mul_sum;
  logic [PROD_W-1:0]   prod;
  logic                out_last;

  // Effective frame size and the threshold for a result to be due.
  assign w_eff = (width_cfg_r == '0) ? WIDTH_W'(1) :
                 (width_cfg_r > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_cfg_r;
  assign h_eff    = (height_cfg_r == '0) ? HEIGHT_W'(1) : height_cfg_r;
  assign lag_plus = {w_eff, 1'b0} + LAG_W'(3);

  // Input handshake and line store write.
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = in_acc && !in_flush && !in_done_r;
  assign in_eol   = ({1'b0, in_col_r} == w_eff - WIDTH_W'(1));
  assign in_eof   = in_eol && (in_row_r == h_eff - HEIGHT_W'(1));

  // Window tap position and its clipping test.
  assign yy     = {2'b00, out_row_r} + {15'd0, wy_r} - 18'd2;
  assign xx     = {2'b00, out_col_r} + {10'd0, wx_r} - 13'd2;
  assign tap_in = !yy[17] && (yy[16:0] < {1'b0, h_eff}) &&
                  !xx[12] && (xx[11:0] < w_eff);

  bb5_ram #(
    .WIDTH (PIX_W),
    .DEPTH (LS_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr ({in_row_r[RING_W-1:0], in_col_r}),
    .wdata ({in_red_in, in_green_in, in_blue_in}),
    .raddr ({yy[RING_W-1:0], xx[COL_W-1:0]}),
    .rdata (rd_data)
  );

  // One channel per cycle through the reciprocal multiplier.
  always_comb begin
    unique case (ch_r)
      2'd0:    mul_sum = sum_r_r;
      2'd1:    mul_sum = sum_g_r;
      default: mul_sum = sum_b_r;
    endcase
  end
  assign prod     = PROD_W'(mul_sum) * PROD_W'(recip_r);
  assign out_last = ({1'b0, out_col_r} == w_eff - WIDTH_W'(1)) &&
                    (out_row_r == h_eff - HEIGHT_W'(1));

  // Sequencer and counters.
  always_comb begin
    width_cfg_nxt  = width_cfg_r;
    height_cfg_nxt = height_cfg_r;
    in_col_nxt     = in_col_r;
    in_row_nxt     = in_row_r;
    in_done_nxt    = in_done_r;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    diff_nxt       = diff_r;
    state_nxt      = state_r;
    wy_nxt         = wy_r;
    wx_nxt         = wx_r;
    rd_vld_nxt     = 1'b0;
    sum_r_nxt      = sum_r_r;
    sum_g_nxt      = sum_g_r;
    sum_b_nxt      = sum_b_r;
    cnt_nxt        = cnt_r;
    recip_nxt      = recip_r;
    ch_nxt         = ch_r;
    out_valid_nxt  = out_valid_r && out_stall;
    red_nxt        = red_r;
    green_nxt      = green_r;
    blue_nxt       = blue_r;
    last_nxt       = last_r;

    // Accumulate the tap read in the previous cycle.
    if (rd_vld_r) begin
      sum_r_nxt = sum_r_r + SUM_W'(rd_data[23:16]);
      sum_g_nxt = sum_g_r + SUM_W'(rd_data[15:8]);
      sum_b_nxt = sum_b_r + SUM_W'(rd_data[7:0]);
      cnt_nxt   = cnt_r + CNT_W'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (wr_en) begin
            diff_nxt = diff_r + LAG_W'(1);
            if (in_eof) begin
              in_done_nxt = 1'b1;
            end
            if (in_eol) begin
              in_col_nxt = '0;
              in_row_nxt = in_row_r + HEIGHT_W'(1);
            end else begin
              in_col_nxt = in_col_r + COL_W'(1);
            end
          end
          if (in_done_nxt || (diff_nxt >= lag_plus)) begin
            state_nxt = S_SUM;
            wy_nxt    = '0;
            wx_nxt    = '0;
            sum_r_nxt = '0;
            sum_g_nxt = '0;
            sum_b_nxt = '0;
            cnt_nxt   = '0;
          end
        end
      end
      S_SUM: begin
        rd_vld_nxt = tap_in;
        if (wx_r == WIDX_W'(WIN - 1)) begin
          wx_nxt = '0;
          if (wy_r == WIDX_W'(WIN - 1)) begin
            state_nxt = S_DRAIN;
          end else begin
            wy_nxt = wy_r + WIDX_W'(1);
          end
        end else begin
          wx_nxt = wx_r + WIDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_RCP;
      end
      S_RCP: begin
        recip_nxt = recip(cnt_r);
        ch_nxt    = 2'd0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        unique case (ch_r)
          2'd0:    red_nxt   = prod[RCP_SHIFT+7:RCP_SHIFT];
          2'd1:    green_nxt = prod[RCP_SHIFT+7:RCP_SHIFT];
          default: blue_nxt  = prod[RCP_SHIFT+7:RCP_SHIFT];
        endcase
        ch_nxt = ch_r + 2'd1;
        if (ch_r == 2'd2) begin
          out_valid_nxt = 1'b1;
          last_nxt      = out_last;
          state_nxt     = S_IDLE;
          if (out_last) begin
            in_col_nxt  = '0;
            in_row_nxt  = '0;
            in_done_nxt = 1'b0;
            out_col_nxt = '0;
            out_row_nxt = '0;
            diff_nxt    = '0;
          end else begin
            diff_nxt = diff_r - LAG_W'(1);
            if ({1'b0, out_col_r} == w_eff - WIDTH_W'(1)) begin
              out_col_nxt = '0;
              out_row_nxt = out_row_r + HEIGHT_W'(1);
            end else begin
              out_col_nxt = out_col_r + COL_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Register writes restart the frame.
    if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_cfg_nxt  = cfg_wdata[WIDTH_W-1:0];
        REG_HEIGHT: height_cfg_nxt = cfg_wdata[HEIGHT_W-1:0];
      endcase
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      in_done_nxt = 1'b0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      diff_nxt    = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= WIDTH_W'(640);
      height_cfg_r <= HEIGHT_W'(480);
      in_col_r     <= '0;
      in_row_r     <= '0;
      in_done_r    <= 1'b0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      diff_r       <= '0;
      state_r      <= S_IDLE;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      width_cfg_r  <= width_cfg_nxt;
      height_cfg_r <= height_cfg_nxt;
      in_col_r     <= in_col_nxt;
      in_row_r     <= in_row_nxt;
      in_done_r    <= in_done_nxt;
      out_col_r    <= out_col_nxt;
      out_row_r    <= out_row_nxt;
      diff_r       <= diff_nxt;
      state_r      <= state_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    wy_r    <= wy_nxt;
    wx_r    <= wx_nxt;
    sum_r_r <= sum_r_nxt;
    sum_g_r <= sum_g_nxt;
    sum_b_r <= sum_b_nxt;
    cnt_r   <= cnt_nxt;
    recip_r <= recip_nxt;
    ch_r    <= ch_nxt;
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_red_out    = red_r;
  assign out_green_out  = green_r;
  assign out_blue_out   = blue_r;
  assign out_frame_last = last_r;

`ifndef SYNTH
  // Input never runs more than one window lag ahead of the output.
  a_lag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    diff_r <= lag_plus)
    else $error("input ran ahead of the output by more than the window lag");

  // The window always holds at least its center pixel.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RCP) |-> (cnt_r != '0))
    else $error("empty window reached the divider");

  // The last channel product always posts a result beat.
  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && ch_r == 2'd2) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not posted after the divide");

  // Line store reads are only issued while the window is walked.
  a_read_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> ($past(state_r) == S_SUM))
    else $error("line store read outside the window walk");
`endif

endmodule
`default_nettype wire
